### rtl/cma_pkg.sv
`default_nettype none

package cma_pkg;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        last_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        last_out;
    } t_out_word;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index REG_BRIGHTNESS = 2'd0;
    localparam t_cfg_index REG_CONTRAST   = 2'd1;
    localparam t_cfg_index REG_SATURATION = 2'd2;

    // luminance weights in thousandths
    localparam int K_PERMILLE [3] = '{213, 715, 72};

    // cycles the coefficient pipeline needs after a register changes
    localparam logic [1:0] SETTLE_CYC = 2'd3;

endpackage

`default_nettype wire

### rtl/cma_coef.sv
`default_nettype none

module cma_coef #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire  cma_pkg::t_cfg_index         i_cfg_index,
    input  wire  [7:0]                        i_cfg_data,
    output logic                              o_cfg_ready,
    output logic                              o_coef_busy,
    output logic signed [2*COEF_FRAC_BITS+3:0]  o_a [3][3],
    output logic signed [2*COEF_FRAC_BITS+13:0] o_b [3]
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 3;
    localparam int OW = F + 10;
    localparam int AW = 2 * F + 4;
    localparam int SW = 2 * F + 14;
    localparam int BW = OW + CW;
    localparam longint ONE_L = longint'(1) << F;

    function automatic longint f_rdiv100(input longint n);
        longint m;
        longint q;
        m = n + 50;
        q = m / 100;
        if ((m % 100) != 0 && m < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint f_rdiv1000(input longint n);
        longint m;
        longint q;
        m = n + 500;
        q = m / 1000;
        if ((m % 1000) != 0 && m < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    logic signed [CW-1:0] w_gain [256];
    logic signed [OW-1:0] w_oc   [256];
    logic signed [OW-1:0] w_ob   [256];
    logic signed [CW-1:0] w_mk   [3][256];

    for (genvar g = 0; g < 256; g++) begin : g_tab
        localparam longint V    = (g >= 128) ? longint'(g) - 256 : longint'(g);
        localparam longint GAIN = f_rdiv100((100 + V) * ONE_L);
        localparam longint OC   = 128 * (ONE_L - GAIN);
        localparam longint OB   = f_rdiv100(255 * V * ONE_L);
        assign w_gain[g] = GAIN[CW-1:0];
        assign w_oc[g]   = OC[OW-1:0];
        assign w_ob[g]   = OB[OW-1:0];
        for (genvar j = 0; j < 3; j++) begin : g_k
            localparam longint MK =
                f_rdiv1000(longint'(cma_pkg::K_PERMILLE[j]) * (ONE_L - GAIN));
            assign w_mk[j][g] = MK[CW-1:0];
        end
    end

    logic [7:0] r_bright;
    logic [7:0] r_contr;
    logic [7:0] r_sat;
    logic [1:0] r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
            r_contr  <= '0;
            r_sat    <= '0;
            r_settle <= cma_pkg::SETTLE_CYC;
        end else begin
            if (i_cfg_valid) begin
                r_settle <= cma_pkg::SETTLE_CYC;
                unique case (i_cfg_index)
                    cma_pkg::REG_BRIGHTNESS: begin
                        r_bright <= i_cfg_data;
                    end
                    cma_pkg::REG_CONTRAST: begin
                        r_contr <= i_cfg_data;
                    end
                    cma_pkg::REG_SATURATION: begin
                        r_sat <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_coef_busy = (r_settle != 2'd0);

    // table lookup stage
    logic signed [CW-1:0] r_cq;
    logic signed [OW-1:0] r_oq;
    logic signed [CW-1:0] r_m [3][3];

    always_ff @(posedge i_clk) begin
        r_cq <= w_gain[r_contr];
        r_oq <= w_oc[r_contr] + w_ob[r_bright];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_m[i][j] <= (i == j) ? w_mk[j][r_sat] + w_gain[r_sat] : w_mk[j][r_sat];
            end
        end
    end

    // gain times matrix, row sums
    logic signed [2*CW-1:0] w_cm [3][3];
    logic signed [CW+1:0]   w_ms [3];
    logic signed [AW-1:0]   r_a  [3][3];
    logic signed [CW-1:0]   r_ms [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_cm[i][j] = r_cq * r_m[i][j];
            end
            w_ms[i] = {{2{r_m[i][0][CW-1]}}, r_m[i][0]}
                    + {{2{r_m[i][1][CW-1]}}, r_m[i][1]}
                    + {{2{r_m[i][2][CW-1]}}, r_m[i][2]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_a[i][j] <= w_cm[i][j][AW-1:0];
            end
            r_ms[i] <= w_ms[i][CW-1:0];
        end
    end

    // offset times row sum
    logic signed [BW-1:0] w_bp [3];
    logic signed [SW-1:0] r_b  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_bp[i] = r_oq * r_ms[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_b[i] <= {{(SW-BW){w_bp[i][BW-1]}}, w_bp[i]};
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

`default_nettype wire

### rtl/color_matrix_adjust_unit.sv
`default_nettype none

// Brightness, contrast and saturation adjustment of ARGB8888 pixels.
// Input: a word (pixel, last flag) is taken at a clock edge where start is
// high and busy is low. Output: o_done is high for one cycle with the
// adjusted word on o_out; alpha and last are passed along unchanged.
// A taken word moves through r_in, r_p, r_q/r_r, r_t, r_out. Throughput:
// one pixel per clock unless busy, every stage registered (multiply, two
// adder levels, round and clamp), so start may stay high continuously.
// Config: registers brightness (0), contrast (1) and saturation (2) are
// written over the i_cfg_* channel, always ready. Writes are meant for an
// idle block; after each write busy is high while the coefficient
// pipeline (table lookup, gain multiply, offset multiply) settles.
// Reset: synchronous, active low; registers go to zero, the pipeline
// empties and busy is high afterwards until the coefficients settle.
// The receiver cannot stall: every result is strobed exactly once.
module color_matrix_adjust_unit #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire  cma_pkg::t_in_word   i_in,
    output logic                      o_done,
    output cma_pkg::t_out_word        o_out,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  cma_pkg::t_cfg_index i_cfg_index,
    input  wire  [7:0]                i_cfg_data
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int AW = 2 * F + 4;
    localparam int PW = AW + 9;
    localparam int SW = 2 * F + 14;
    localparam logic signed [SW-1:0] HALF = {{(SW-2*F){1'b0}}, 1'b1, {(2*F-1){1'b0}}};

    logic signed [AW-1:0] w_a [3][3];
    logic signed [SW-1:0] w_b [3];
    logic                 w_coef_busy;

    cma_coef #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .o_coef_busy(w_coef_busy),
        .o_a        (w_a),
        .o_b        (w_b)
    );

    assign busy = w_coef_busy;

    logic w_take;
    assign w_take = start && !w_coef_busy;

    // valid bits of stages 1..4 and output
    logic [3:0] r_vld;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[2:0], w_take};
            r_done <= r_vld[3];
        end
    end

    cma_pkg::t_in_word r_in;
    logic [7:0]        r_alpha2, r_alpha3, r_alpha4;
    logic              r_last2, r_last3, r_last4;

    logic signed [8:0]    w_x [3];
    logic signed [PW-1:0] w_p [3][3];
    logic signed [SW-1:0] r_p [3][3];
    logic signed [SW-1:0] r_q [3];
    logic signed [SW-1:0] r_r [3];
    logic signed [SW-1:0] r_t [3];
    logic [7:0]           w_ch [3];
    cma_pkg::t_out_word   r_out;

    always_comb begin
        w_x[0] = {1'b0, r_in.pixel_in[23:16]};
        w_x[1] = {1'b0, r_in.pixel_in[15:8]};
        w_x[2] = {1'b0, r_in.pixel_in[7:0]};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_p[i][j] = w_a[i][j] * w_x[j];
            end
        end
    end

    // round already added; clamp to 0..255
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_t[i][SW-1]) begin
                w_ch[i] = 8'h00;
            end else if (|r_t[i][SW-2:2*F+8]) begin
                w_ch[i] = 8'hFF;
            end else begin
                w_ch[i] = r_t[i][2*F+7:2*F];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in;
        end
        r_alpha2 <= r_in.pixel_in[31:24];
        r_last2  <= r_in.last_in;
        r_alpha3 <= r_alpha2;
        r_last3  <= r_last2;
        r_alpha4 <= r_alpha3;
        r_last4  <= r_last3;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[i][j] <= {{(SW-PW){w_p[i][j][PW-1]}}, w_p[i][j]};
            end
            r_q[i] <= r_p[i][0] + r_p[i][1];
            r_r[i] <= r_p[i][2] + w_b[i];
            r_t[i] <= r_q[i] + r_r[i] + HALF;
        end
        r_out.pixel_out <= {r_alpha4, w_ch[0], w_ch[1], w_ch[2]};
        r_out.last_out  <= r_last4;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 740;
    localparam int CALM_WORDS = 120;
    localparam cma_pkg::t_cfg_index REG_UNUSED = 2'd3;
    localparam longint LUMA_PERMILLE [3] = '{213, 715, 72};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    cma_pkg::t_in_word   in_word = '0;
    logic                o_done;
    cma_pkg::t_out_word  o_out;
    logic                cfg_valid = 1'b0;
    logic                o_cfg_ready;
    cma_pkg::t_cfg_index cfg_index = cma_pkg::REG_BRIGHTNESS;
    logic [7:0]          cfg_data = 8'd0;

    logic signed [7:0] bright_pct = 8'sd0;
    logic signed [7:0] contrast_pct = 8'sd0;
    logic signed [7:0] sat_pct = 8'sd0;

    cma_pkg::t_out_word adjusted_pixels_q [$];
    cma_pkg::t_out_word head_word;
    int                 err_cnt = 0;
    int                 stall_cycles = 0;

    color_matrix_adjust_unit #(
        .COEF_FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (in_word),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // floor((n + d/2) / d)
    function automatic longint floor_round(input longint n, input longint d);
        longint m;
        longint q;
        m = n + d / 2;
        q = m / d;
        if ((m % d) != 0 && m < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [7:0] clamp_channel(input longint sum);
        longint v;
        v = sum + (longint'(1) <<< (2 * FRAC - 1));
        if (v < 0)
            return 8'd0;
        v = v >>> (2 * FRAC);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic cma_pkg::t_out_word adjust_pixel(input cma_pkg::t_in_word w);
        longint             unity;
        longint             gain;
        longint             sat;
        longint             ofs;
        longint             sum;
        longint             m;
        longint             lin [3];
        logic [7:0]         chan [3];
        cma_pkg::t_out_word r;
        unity = longint'(1) <<< FRAC;
        gain = floor_round((100 + longint'(contrast_pct)) * unity, 100);
        sat = floor_round((100 + longint'(sat_pct)) * unity, 100);
        ofs = 128 * (unity - gain) + floor_round(255 * longint'(bright_pct) * unity, 100);
        for (int j = 0; j < 3; j++)
            lin[j] = gain * longint'(w.pixel_in[23 - 8 * j -: 8]) + ofs;
        for (int i = 0; i < 3; i++) begin
            sum = 0;
            for (int j = 0; j < 3; j++) begin
                m = floor_round(LUMA_PERMILLE[j] * (unity - sat), 1000);
                if (i == j)
                    m = m + sat;
                sum = sum + m * lin[j];
            end
            chan[i] = clamp_channel(sum);
        end
        r.pixel_out = {w.pixel_in[31:24], chan[0], chan[1], chan[2]};
        r.last_out = w.last_in;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v, $time);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (adjusted_pixels_q.size() == 0) begin
                    note_mismatch("unexpected word", 32'd0, o_out.pixel_out);
                end else begin
                    head_word = adjusted_pixels_q.pop_front();
                    if (head_word.pixel_out !== o_out.pixel_out)
                        note_mismatch("pixel_out", head_word.pixel_out, o_out.pixel_out);
                    if (head_word.last_out !== o_out.last_out)
                        note_mismatch("last_out", {31'd0, head_word.last_out},
                                      {31'd0, o_out.last_out});
                end
            end
            if (o_done || (start && !busy) || (cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [31:0] px, input logic last);
        cma_pkg::t_in_word w;
        w.pixel_in = px;
        w.last_in = last;
        @(negedge i_clk);
        start <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (busy);
        adjusted_pixels_q.push_back(adjust_pixel(w));
    endtask

    task automatic idle_gap(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_words;
        @(negedge i_clk);
        start <= 1'b0;
        while (adjusted_pixels_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input cma_pkg::t_cfg_index idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cma_pkg::REG_BRIGHTNESS: bright_pct = val;
            cma_pkg::REG_CONTRAST:   contrast_pct = val;
            cma_pkg::REG_SATURATION: sat_pct = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] b, input logic [7:0] c, input logic [7:0] s);
        write_reg(cma_pkg::REG_BRIGHTNESS, b);
        write_reg(cma_pkg::REG_CONTRAST, c);
        write_reg(cma_pkg::REG_SATURATION, s);
    endtask

    function automatic logic [7:0] rand_pct;
        case ($urandom_range(0, 5))
            0: return 8'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 8'sd100;
                    1: return -8'sd100;
                    2: return 8'sd127;
                    default: return 8'h80;
                endcase
            end
            default: return 8'($urandom_range(0, 200) - 100);
        endcase
    endfunction

    function automatic logic [31:0] rand_pixel;
        logic [31:0] px;
        px = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int j = 0; j < 3; j++)
                px[8 * j +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    task automatic test_default_config;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h8080_8080, 1'b0);
        send_word(32'h00FF_0000, 1'b0);
        send_word(32'h0000_FF00, 1'b1);
        send_word(32'h5500_00FF, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        drain_words;
    endtask

    task automatic test_register_extremes;
        logic [7:0] levels [4][3];
        levels = '{'{8'sd127, 8'sd127, 8'sd127}, '{8'h80, 8'h80, 8'h80},
                   '{8'sd100, -8'sd100, 8'sd100}, '{-8'sd100, 8'sd100, -8'sd100}};
        for (int k = 0; k < 4; k++) begin
            write_all(levels[k][0], levels[k][1], levels[k][2]);
            // unknown index must leave the registers alone
            if (k == 1)
                write_reg(REG_UNUSED, 8'h7F);
            send_word(32'h0000_0000, 1'b1);
            send_word(32'hFFFF_FFFF, 1'b0);
            send_word(32'h12FF_8000, 1'b0);
            send_word(32'hED00_7FFF, 1'b1);
            drain_words;
        end
    endtask

    task automatic test_random_stream;
        int  n_sent;
        int  phase_len;
        bit  gaps_on;
        bit  paused;
        n_sent = 0;
        paused = 1'b0;
        while (n_sent < RANDOM_WORDS) begin
            write_all(rand_pct(), rand_pct(), rand_pct());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 8'($urandom));
            phase_len = $urandom_range(20, 80);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < phase_len && n_sent < RANDOM_WORDS; i++) begin
                send_word(rand_pixel(), $urandom_range(0, 7) == 0);
                n_sent++;
                if (!paused && i == phase_len / 2) begin
                    drain_words;
                    paused = 1'b1;
                end else if (gaps_on && n_sent < RANDOM_WORDS - CALM_WORDS
                             && $urandom_range(0, 3) == 0) begin
                    idle_gap($urandom_range(1, 8));
                end
            end
            drain_words;
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config;
        test_register_extremes;
        test_random_stream;
        drain_words;
        repeat (10) @(posedge i_clk);
        if (adjusted_pixels_q.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
